/* rtl/greedy_gap_filler_select_unit_assert.svh */
// Assertion macros for the greedy gap filler select unit.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef GREEDY_GAP_FILLER_SELECT_UNIT_ASSERT_SVH
`define GREEDY_GAP_FILLER_SELECT_UNIT_ASSERT_SVH

// property must hold in the same cycle
`define GFS_ASSERT_NOW(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/gfs_pkg.sv */
// Shared widths, sequencer states and divider status for the gap filler select unit.
// No dependencies.
`default_nettype none

package gfs_pkg;

	localparam int GAP_W     = 10;
	localparam int WID_W     = 8;
	localparam int SLOT_W    = 3;
	localparam int CFG_IDX_W = 3;
	localparam int DIV_STEPS = GAP_W;
	localparam int STEP_W    = $clog2(DIV_STEPS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_FINAL
	} gfs_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} gfs_div_stat_t;

endpackage

`default_nettype wire

/* rtl/gfs_div.sv */
// Restoring bit-serial divider: gap remainder by one filler width, one quotient bit per cycle.
// Depends on gfs_pkg.
`default_nettype none

module gfs_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [gfs_pkg::GAP_W-1:0]  dividend,
	input  wire logic [gfs_pkg::WID_W-1:0]  divisor,
	output logic      [gfs_pkg::GAP_W-1:0]  quotient,
	output logic      [gfs_pkg::WID_W-1:0]  remainder,
	output gfs_pkg::gfs_div_stat_t          stat
);
	import gfs_pkg::*;

	logic [GAP_W-1:0]  quo_q;
	logic [WID_W-1:0]  rem_q;
	logic [WID_W-1:0]  dvs_q;
	logic [STEP_W-1:0] step_q;
	logic              done_q;

	logic [WID_W:0]    trial;
	logic [WID_W:0]    diff;
	logic              ge;
	logic [WID_W-1:0]  rem_nxt;

	always_comb begin
		trial   = {rem_q, quo_q[GAP_W-1]};
		diff    = trial - {1'b0, dvs_q};
		ge      = (trial >= {1'b0, dvs_q});
		rem_nxt = ge ? diff[WID_W-1:0] : trial[WID_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				step_q <= STEP_W'(DIV_STEPS);
			end else if (step_q != '0) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1))
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (step_q != '0) begin
			quo_q <= {quo_q[GAP_W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign stat.busy = (step_q != '0);
	assign stat.done = done_q;

endmodule

`default_nettype wire

/* rtl/greedy_gap_filler_select_unit.sv */
// Greedy gap filler select unit: splits a gap into configured filler widths, slot 0 first.
// Slots with a zero width are skipped; each other slot is divided by the bit-serial divider
// (one quotient bit per cycle). Next gap taken once idle; a new gap is not taken while one
// is in progress. Results leave as found, final one flagged; receiver cannot stall.
// Reset clears filler widths to zero and returns the sequencer to idle.
`default_nettype none

`include "greedy_gap_filler_select_unit_assert.svh"

module greedy_gap_filler_select_unit #(
	parameter int NUM_TYPES = 8,
	parameter int MAX_GAP   = 1023
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [gfs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [gfs_pkg::WID_W-1:0]     cfg_data,
	input  wire logic                          start,
	input  wire logic [gfs_pkg::GAP_W-1:0]     gap_sites,
	output logic                               busy,
	output logic                               result_strobe,
	output logic      [gfs_pkg::SLOT_W-1:0]    filler_slot,
	output logic      [gfs_pkg::GAP_W-1:0]     piece_count,
	output logic                               fill_failed,
	output logic                               last_result
);
	import gfs_pkg::*;

	logic [WID_W-1:0]  width_q [NUM_TYPES];

	gfs_state_t        state_q, state_d;
	logic [GAP_W-1:0]  left_q;
	logic              over_q;
	logic [SLOT_W-1:0] slot_q;
	logic              pend_v_q;
	logic [SLOT_W-1:0] pend_slot_q;
	logic [GAP_W-1:0]  pend_cnt_q;

	logic              strobe_q;
	logic [SLOT_W-1:0] slot_out_q;
	logic [GAP_W-1:0]  cnt_out_q;
	logic              failed_q;
	logic              last_q;

	logic [WID_W-1:0]  w_cur;
	logic              slot_end;
	logic              accept;
	logic              div_start;
	logic              adv;
	logic              take;
	logic              emit;
	logic [SLOT_W-1:0] emit_slot;
	logic [GAP_W-1:0]  emit_cnt;
	logic              emit_failed;
	logic              emit_last;

	logic [GAP_W-1:0]  div_quo;
	logic [WID_W-1:0]  div_rem;
	gfs_div_stat_t     div_stat;

	// filler width registers
	for (genvar i = 0; i < NUM_TYPES; i++) begin : g_width
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				width_q[i] <= '0;
			else if (cfg_we && cfg_index == CFG_IDX_W'(i))
				width_q[i] <= cfg_data;
		end
	end

	always_comb begin
		w_cur = '0;
		for (int i = 0; i < NUM_TYPES; i++)
			if (slot_q == SLOT_W'(i))
				w_cur = width_q[i];
	end

	assign slot_end = (slot_q == SLOT_W'(NUM_TYPES - 1));
	assign accept   = start && (state_q == ST_IDLE);

	gfs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (left_q),
		.divisor   (w_cur),
		.quotient  (div_quo),
		.remainder (div_rem),
		.stat      (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		div_start   = 1'b0;
		adv         = 1'b0;
		take        = 1'b0;
		emit        = 1'b0;
		emit_slot   = pend_slot_q;
		emit_cnt    = pend_cnt_q;
		emit_failed = 1'b0;
		emit_last   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (over_q || left_q == '0) begin
					state_d = ST_FINAL;
				end else if (w_cur == '0) begin
					if (slot_end)
						state_d = ST_FINAL;
					else
						adv = 1'b1;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					if (div_quo != '0) begin
						take = 1'b1;
						emit = pend_v_q;
					end
					if (slot_end) begin
						state_d = ST_FINAL;
					end else begin
						adv     = 1'b1;
						state_d = ST_SCAN;
					end
				end
			end
			ST_FINAL: begin
				emit        = 1'b1;
				emit_last   = 1'b1;
				emit_failed = over_q || (left_q != '0);
				if (!pend_v_q) begin
					emit_slot = '0;
					emit_cnt  = '0;
				end
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emit;
			if (accept)
				pend_v_q <= 1'b0;
			else if (take)
				pend_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			left_q <= gap_sites;
			over_q <= (int'(gap_sites) > MAX_GAP);
			slot_q <= '0;
		end else begin
			if (adv)
				slot_q <= slot_q + SLOT_W'(1);
			if (take) begin
				left_q      <= GAP_W'(div_rem);
				pend_slot_q <= slot_q;
				pend_cnt_q  <= div_quo;
			end
		end
		if (emit) begin
			slot_out_q <= emit_slot;
			cnt_out_q  <= emit_cnt;
			failed_q   <= emit_failed;
			last_q     <= emit_last;
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign result_strobe = strobe_q;
	assign filler_slot   = slot_out_q;
	assign piece_count   = cnt_out_q;
	assign fill_failed   = failed_q;
	assign last_result   = last_q;

	`GFS_ASSERT_NOW(a_last_ends_busy, clk, arst_n,
		result_strobe |-> (last_result == !busy), "final flag out of step with busy")
	`GFS_ASSERT_NOW(a_fail_only_last, clk, arst_n,
		(result_strobe && fill_failed) |-> last_result, "failure flag on a non-final result")
	`GFS_ASSERT_NOW(a_mid_count, clk, arst_n,
		(result_strobe && !last_result) |-> (piece_count != '0), "empty non-final result")
	`GFS_ASSERT_NEXT(a_accept_busy, clk, arst_n,
		start && !busy, busy, "request accepted but unit not busy")
	`GFS_ASSERT_NOW(a_div_idle, clk, arst_n,
		(state_q != ST_DIV) |-> !div_stat.busy, "divider running outside divide state")

endmodule

`default_nettype wire
